[rtl/neighbor_table_with_aging_top_assert.svh]
// assertion macros for the neighbor table with aging
// used by the top level; needs nothing else
`ifndef NEIGHBOR_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_TOP_ASSERT_SVH

// same-cycle implication
`define NTA_ASSERT_HOLD(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/nta_pkg.sv]
// types and fixed constants of the neighbor table with aging
// no dependencies
package nta_pkg;

   localparam int IFACE_BITS    = 2;
   localparam int ID_BITS       = 32;
   localparam int LIFE_BITS     = 10;
   localparam int COUNT_BITS    = 5;
   localparam int INTERVAL_BITS = 8;
   localparam int LIFE_FACTOR   = 3;

   localparam logic [INTERVAL_BITS-1:0] HELLO_INTERVAL_RESET = 8'd5;

   localparam logic KIND_HELLO = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef struct packed {
      logic [IFACE_BITS-1:0] iface;
      logic [ID_BITS-1:0]    router_id;
      logic [ID_BITS-1:0]    address;
      logic [ID_BITS-1:0]    mask;
      logic [LIFE_BITS-1:0]  lifetime;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic rd_en;
      logic check;
      logic finish;
   } seq_type;

   function automatic logic [LIFE_BITS-1:0] lifetime_of(input logic [INTERVAL_BITS-1:0] iv);
      return LIFE_BITS'(LIFE_FACTOR * int'(iv));
   endfunction

endpackage

[rtl/neighbor_table_with_aging_top.sv]
// neighbor table with aging: top level with entry datapath, valid bits and counts
// depends on nta_pkg, nta_ram, nta_seq and the assertion macro header
//
// Usage:
//   req_* carries one beat per hello (req_kind = 0) or aging tick (req_kind = 1).
//   A beat is taken when req_valid is high and req_stall is low. rsp_* returns
//   exactly one beat per request, taken when rsp_valid is high and rsp_stall low.
//   csr_hello_interval is written over the csr_valid/csr_ready channel while the
//   block is idle; the user must keep to this, as the block does not enforce it.
//   csr_ready is always high. Each request walks the whole entry memory, one
//   entry read per cycle through the single read port, then a drain step for the
//   last check and a finish step that registers the result beat; a new request
//   is taken once the block is back in idle, after that finish step is done.
//   A waiting result does not block the next request; only the finish step of
//   that next request waits while rsp_stall holds the previous beat.
//   Reset empties the table, clears the interface counts and sets the hello
//   interval to 5. No clearing pass is needed: entry validity lives in flops.
`include "neighbor_table_with_aging_top_assert.svh"

module neighbor_table_with_aging_top #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IFACE_COUNT   = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [nta_pkg::IFACE_BITS-1:0]      req_iface_index,
   input  logic [nta_pkg::ID_BITS-1:0]         req_router_id,
   input  logic [nta_pkg::ID_BITS-1:0]         req_source_ip,
   input  logic [nta_pkg::ID_BITS-1:0]         req_net_mask,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_changed,
   output logic [nta_pkg::COUNT_BITS-1:0]      rsp_neighbor_count,
   output logic                                rsp_table_full,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nta_pkg::INTERVAL_BITS-1:0]   csr_hello_interval
);
   import nta_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = (TABLE_ENTRIES >= 31) ? $clog2(TABLE_ENTRIES + 1) : COUNT_BITS;
   localparam int SUM_W = CNT_W + 4;

   seq_type          seq;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] chk_idx;
   logic             req_accept;
   logic             out_free;

   entry_type        rd_entry;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   logic [INTERVAL_BITS-1:0] interval_ff, interval_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]         cnt_ff [IFACE_COUNT];
   logic [CNT_W-1:0]         cnt_in [IFACE_COUNT];

   logic                  op_kind_ff, op_kind_in;
   logic [IFACE_BITS-1:0] op_iface_ff, op_iface_in;
   logic [ID_BITS-1:0]    op_rid_ff, op_rid_in;
   logic [ID_BITS-1:0]    op_addr_ff, op_addr_in;
   logic [ID_BITS-1:0]    op_mask_ff, op_mask_in;

   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             changed_ff, changed_in;
   logic [CNT_W-1:0] total_ff, total_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_changed_ff, rsp_changed_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic             iface_ok;
   logic [CNT_W-1:0] cur_cnt;
   logic [SUM_W-1:0] cnt_sum;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = seq.busy;
   assign csr_ready  = 1'b1;

   nta_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .out_free   (out_free),
      .seq        (seq),
      .rd_addr    (rd_addr),
      .chk_idx    (chk_idx)
   );

   nta_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (seq.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // interface range and current count of the request's interface
   always_comb begin
      iface_ok = int'(op_iface_ff) < IFACE_COUNT;
      cur_cnt  = '0;
      for (int i = 0; i < IFACE_COUNT; i++) begin
         if (int'(op_iface_ff) == i) begin
            cur_cnt = cnt_ff[i];
         end
      end
   end

   always_comb begin
      interval_in = interval_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      op_kind_in  = op_kind_ff;
      op_iface_in = op_iface_ff;
      op_rid_in   = op_rid_ff;
      op_addr_in  = op_addr_ff;
      op_mask_in  = op_mask_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      changed_in  = changed_ff;
      total_in    = total_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_full_in    = rsp_full_ff;
      wr_en   = 1'b0;
      wr_addr = chk_idx;
      wr_data = rd_entry;

      if (csr_valid && csr_ready) begin
         interval_in = csr_hello_interval;
      end

      if (req_accept) begin
         op_kind_in  = req_kind;
         op_iface_in = req_iface_index;
         op_rid_in   = req_router_id;
         op_addr_in  = req_source_ip;
         op_mask_in  = req_net_mask;
         hit_in      = 1'b0;
         free_in     = 1'b0;
         changed_in  = 1'b0;
         total_in    = '0;
      end

      // check stage: one entry per cycle
      if (seq.check) begin
         if (op_kind_ff == KIND_HELLO) begin
            if (valid_ff[chk_idx]) begin
               if (!hit_ff && rd_entry.iface == op_iface_ff &&
                   rd_entry.router_id == op_rid_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx;
               end
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx;
            end
         end else if (valid_ff[chk_idx]) begin
            if (rd_entry.lifetime <= LIFE_BITS'(1)) begin
               valid_in[chk_idx] = 1'b0;
               changed_in        = 1'b1;
               for (int i = 0; i < IFACE_COUNT; i++) begin
                  if (int'(rd_entry.iface) == i && cnt_ff[i] != '0) begin
                     cnt_in[i] = cnt_ff[i] - 1'b1;
                  end
               end
            end else begin
               wr_en            = 1'b1;
               wr_addr          = chk_idx;
               wr_data          = rd_entry;
               wr_data.lifetime = rd_entry.lifetime - 1'b1;
               total_in         = total_ff + 1'b1;
            end
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // finish step: hello write-back and result beat
      if (seq.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_changed_in = 1'b0;
         rsp_full_in    = 1'b0;
         rsp_count_in   = '0;
         if (op_kind_ff == KIND_TICK) begin
            rsp_changed_in = changed_ff;
            rsp_count_in   = total_ff[COUNT_BITS-1:0];
         end else if (iface_ok) begin
            wr_data.iface     = op_iface_ff;
            wr_data.router_id = op_rid_ff;
            wr_data.address   = op_addr_ff;
            wr_data.mask      = op_mask_ff;
            wr_data.lifetime  = lifetime_of(interval_ff);
            priority if (hit_ff) begin
               wr_en        = 1'b1;
               wr_addr      = hit_idx_ff;
               rsp_count_in = cur_cnt[COUNT_BITS-1:0];
            end else if (free_ff) begin
               wr_en                 = 1'b1;
               wr_addr               = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               for (int i = 0; i < IFACE_COUNT; i++) begin
                  if (int'(op_iface_ff) == i) begin
                     cnt_in[i] = cnt_ff[i] + 1'b1;
                  end
               end
               rsp_changed_in = 1'b1;
               rsp_count_in   = COUNT_BITS'(cur_cnt + 1'b1);
            end else begin
               rsp_full_in  = 1'b1;
               rsp_count_in = cur_cnt[COUNT_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= HELLO_INTERVAL_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < IFACE_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         interval_ff  <= interval_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_kind_ff     <= op_kind_in;
      op_iface_ff    <= op_iface_in;
      op_rid_ff      <= op_rid_in;
      op_addr_ff     <= op_addr_in;
      op_mask_ff     <= op_mask_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      changed_ff     <= changed_in;
      total_ff       <= total_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_changed        = rsp_changed_ff;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_table_full     = rsp_full_ff;

   // per-interface counts always add up to the number of valid entries
   always_comb begin
      cnt_sum = '0;
      for (int i = 0; i < IFACE_COUNT; i++) begin
         cnt_sum = cnt_sum + SUM_W'(cnt_ff[i]);
      end
   end

   `NTA_ASSERT_HOLD(a_count_matches_valid, clock, reset, 1'b1,
      int'(cnt_sum) == $countones(valid_ff), "interface counts disagree with valid entries")
   `NTA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept,
      req_stall, "request taken while a walk could not start")
   `NTA_ASSERT_HOLD(a_change_not_full, clock, reset, rsp_valid,
      !(rsp_changed && rsp_table_full), "added and dropped in one beat")
   `NTA_ASSERT_NEXT(a_tick_never_full, clock, reset, seq.finish && op_kind_ff == KIND_TICK,
      !rsp_table_full, "tick reported a full table")

endmodule

[rtl/nta_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module nta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/nta_seq.sv]
// table walk sequencer: read address counter, check stage and finish step
// depends on nta_pkg
module nta_seq #(
   parameter int TABLE_ENTRIES = 16,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic              out_free,
   output nta_pkg::seq_type  seq,
   output logic [IDX_W-1:0]  rd_addr,
   output logic [IDX_W-1:0]  chk_idx
);
   import nta_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             chk_ff;
   logic [IDX_W-1:0] chk_idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      seq.busy   = (state_ff != ST_IDLE);
      seq.rd_en  = (state_ff == ST_SCAN);
      seq.check  = chk_ff;
      seq.finish = (state_ff == ST_FINISH) && out_free;
      rd_addr    = idx_ff;
      chk_idx    = chk_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         chk_ff   <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= idx_ff;
   end

endmodule
